>>> src/rv64im_integer_alu_defines.svh
// Assertion macros used by the integer ALU top level.
`ifndef RV64IM_INTEGER_ALU_DEFINES_SVH
`define RV64IM_INTEGER_ALU_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("next-cycle check failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("same-cycle check failed");
`else
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post)
`endif
`endif

>>> src/rvalu_pkg.sv
// Shared types, constants and helpers of the integer ALU.
`default_nettype none
package rvalu_pkg;
	localparam int XLEN = 64;
	localparam int HALF = 32;

	typedef enum logic [4:0] {
		OP_ADD    = 5'd0,
		OP_SUB    = 5'd1,
		OP_SLL    = 5'd2,
		OP_SLT    = 5'd3,
		OP_SLTU   = 5'd4,
		OP_XOR    = 5'd5,
		OP_SRL    = 5'd6,
		OP_SRA    = 5'd7,
		OP_OR     = 5'd8,
		OP_AND    = 5'd9,
		OP_MUL    = 5'd10,
		OP_MULH   = 5'd11,
		OP_MULHSU = 5'd12,
		OP_MULHU  = 5'd13,
		OP_DIV    = 5'd14,
		OP_DIVU   = 5'd15,
		OP_REM    = 5'd16,
		OP_REMU   = 5'd17,
		OP_ADDW   = 5'd18,
		OP_SUBW   = 5'd19,
		OP_SLLW   = 5'd20,
		OP_SRLW   = 5'd21,
		OP_SRAW   = 5'd22,
		OP_MULW   = 5'd23,
		OP_DIVW   = 5'd24,
		OP_DIVUW  = 5'd25,
		OP_REMW   = 5'd26,
		OP_REMUW  = 5'd27
	} op_t;

	// side information that rides along with a word through the divider
	typedef struct packed {
		op_t             op;
		logic            neg_q;
		logic            neg_r;
		logic [XLEN-1:0] early;
	} div_tag_t;

	function automatic logic [XLEN-1:0] sext32(input logic [HALF-1:0] x);
		sext32 = {{(XLEN-HALF){x[HALF-1]}}, x};
	endfunction

	function automatic logic is_div_op(input op_t op);
		is_div_op = (op == OP_DIV) || (op == OP_DIVU) || (op == OP_REM) || (op == OP_REMU) ||
			(op == OP_DIVW) || (op == OP_DIVUW) || (op == OP_REMW) || (op == OP_REMUW);
	endfunction

	function automatic logic is_word_op(input op_t op);
		is_word_op = (op == OP_DIVW) || (op == OP_DIVUW) || (op == OP_REMW) ||
			(op == OP_REMUW);
	endfunction

	function automatic logic is_rem_op(input op_t op);
		is_rem_op = (op == OP_REM) || (op == OP_REMU) || (op == OP_REMW) ||
			(op == OP_REMUW);
	endfunction

	function automatic logic is_sdiv_op(input op_t op);
		is_sdiv_op = (op == OP_DIV) || (op == OP_REM) || (op == OP_DIVW) || (op == OP_REMW);
	endfunction
endpackage
`default_nettype wire

>>> src/rvalu_div_pipe.sv
// Unsigned restoring divider, one quotient bit per pipeline stage.
`default_nettype none
module rvalu_div_pipe
	import rvalu_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_vld,
	input  wire div_tag_t        in_tag,
	input  wire logic [XLEN-1:0] dividend,
	input  wire logic [XLEN-1:0] divisor,
	output logic                 out_vld,
	output div_tag_t             out_tag,
	output logic [XLEN-1:0]      quotient,
	output logic [XLEN-1:0]      remainder
);
	logic            dv_vld_s [0:XLEN];
	div_tag_t        dv_tag_s [0:XLEN];
	logic [XLEN-1:0] dv_rem_s [0:XLEN];
	logic [XLEN-1:0] dv_quo_s [0:XLEN];
	logic [XLEN-1:0] dv_dvs_s [0:XLEN];

	// stage zero is the input itself
	assign dv_vld_s[0] = in_vld;
	assign dv_tag_s[0] = in_tag;
	assign dv_rem_s[0] = '0;
	assign dv_quo_s[0] = dividend;
	assign dv_dvs_s[0] = divisor;

	for (genvar k = 0; k < XLEN; k++) begin : g_step
		logic [XLEN:0]   trial;
		logic [XLEN+1:0] diff;
		logic            fits;

		// shift in one dividend bit and try the subtract
		always_comb begin
			trial = {dv_rem_s[k], dv_quo_s[k][XLEN-1]};
			diff  = {1'b0, trial} - {2'b00, dv_dvs_s[k]};
			fits  = ~diff[XLEN+1];
		end

		// advance the valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k+1] <= 1'b0;
			end else begin
				dv_vld_s[k+1] <= dv_vld_s[k];
			end
		end

		// advance partial remainder and quotient
		always_ff @(posedge clk) begin
			dv_tag_s[k+1] <= dv_tag_s[k];
			dv_dvs_s[k+1] <= dv_dvs_s[k];
			dv_rem_s[k+1] <= fits ? diff[XLEN-1:0] : trial[XLEN-1:0];
			dv_quo_s[k+1] <= {dv_quo_s[k][XLEN-2:0], fits};
		end
	end

	assign out_vld   = dv_vld_s[XLEN];
	assign out_tag   = dv_tag_s[XLEN];
	assign quotient  = dv_quo_s[XLEN];
	assign remainder = dv_rem_s[XLEN];
endmodule
`default_nettype wire

>>> src/rv64im_integer_alu.sv
// Top level of the RV64IM integer execute unit.
//
//  channel | ports                               | handshake
//  input   | kind, operand_a, operand_b          | start high, busy low
//  result  | alu_result                          | done strobe, one cycle
//
// Every operation runs through the front stages, the 64 one-bit divider
// stages and the result register, all operations alike, so results leave
// in order. A new word is taken every cycle, so busy stays low.
// The multiply uses four 32x32 partial products over three stages.
// Reset clears only the valid bits; results cannot be held off.
`default_nettype none
`include "rv64im_integer_alu_defines.svh"
module rv64im_integer_alu
	import rvalu_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire logic [4:0]      kind,
	input  wire logic [XLEN-1:0] operand_a,
	input  wire logic [XLEN-1:0] operand_b,
	output logic                 done,
	output logic [XLEN-1:0]      alu_result
);
	op_t             op_in;
	logic [XLEN-1:0] simple_res;
	logic [5:0]      sh6;
	logic [4:0]      sh5;
	logic [XLEN-1:0] am;
	logic [XLEN-1:0] bm;
	logic            sgn_a;
	logic            sgn_b;
	logic            by_zero;
	logic            neg_a;
	logic            neg_b;
	logic [XLEN-1:0] mag_a;
	logic [XLEN-1:0] mag_b;

	// stage registers
	logic            vld_s1, vld_s2, vld_s3, vld_s4;
	op_t             op_s1, op_s2, op_s3, op_s4;
	logic [XLEN-1:0] a_s1, a_s2, a_s3;
	logic [XLEN-1:0] b_s1, b_s2, b_s3;
	logic [XLEN-1:0] simple_s1, simple_s2, simple_s3;
	logic [XLEN-1:0] dvd_s1, dvd_s2, dvd_s3, dvd_s4;
	logic [XLEN-1:0] dvs_s1, dvs_s2, dvs_s3, dvs_s4;
	logic            negq_s1, negq_s2, negq_s3, negq_s4;
	logic            negr_s1, negr_s2, negr_s3, negr_s4;
	logic [XLEN-1:0] pp_ll_s2, pp_lh_s2, pp_hl_s2, pp_hh_s2;
	logic [2*XLEN-1:0] prod_s3;
	logic [XLEN-1:0] early_s4;

	logic [XLEN-1:0] mul_hi;
	div_tag_t        tag_in;
	logic            dv_out_vld;
	div_tag_t        dv_out_tag;
	logic [XLEN-1:0] dv_quo;
	logic [XLEN-1:0] dv_rem;
	logic [XLEN-1:0] dv_pick;
	logic [XLEN-1:0] dv_signed;
	logic [XLEN-1:0] final_res;

	logic            done_q;
	logic [XLEN-1:0] result_q;

	assign busy  = 1'b0;
	assign op_in = op_t'(kind);
	assign sh6   = operand_b[5:0];
	assign sh5   = operand_b[4:0];

	// simple operations, computed combinationally
	always_comb begin
		unique case (op_in)
			OP_ADD:  simple_res = operand_a + operand_b;
			OP_SUB:  simple_res = operand_a - operand_b;
			OP_SLL:  simple_res = operand_a << sh6;
			OP_SLT:  simple_res = {{(XLEN-1){1'b0}},
				($signed(operand_a) < $signed(operand_b))};
			OP_SLTU: simple_res = {{(XLEN-1){1'b0}}, (operand_a < operand_b)};
			OP_XOR:  simple_res = operand_a ^ operand_b;
			OP_SRL:  simple_res = operand_a >> sh6;
			OP_SRA:  simple_res = $unsigned($signed(operand_a) >>> sh6);
			OP_OR:   simple_res = operand_a | operand_b;
			OP_AND:  simple_res = operand_a & operand_b;
			OP_ADDW: simple_res = sext32(operand_a[HALF-1:0] + operand_b[HALF-1:0]);
			OP_SUBW: simple_res = sext32(operand_a[HALF-1:0] - operand_b[HALF-1:0]);
			OP_SLLW: simple_res = sext32(operand_a[HALF-1:0] << sh5);
			OP_SRLW: simple_res = sext32(operand_a[HALF-1:0] >> sh5);
			OP_SRAW: simple_res = sext32($unsigned($signed(operand_a[HALF-1:0]) >>> sh5));
			default: simple_res = '0;
		endcase
	end

	// prepare divider magnitudes; divide by zero passes the dividend unsigned
	always_comb begin
		am      = is_word_op(op_in) ? {{(XLEN-HALF){1'b0}}, operand_a[HALF-1:0]} : operand_a;
		bm      = is_word_op(op_in) ? {{(XLEN-HALF){1'b0}}, operand_b[HALF-1:0]} : operand_b;
		sgn_a   = is_word_op(op_in) ? am[HALF-1] : am[XLEN-1];
		sgn_b   = is_word_op(op_in) ? bm[HALF-1] : bm[XLEN-1];
		by_zero = (bm == '0);
		neg_a   = is_sdiv_op(op_in) && !by_zero && sgn_a;
		neg_b   = is_sdiv_op(op_in) && !by_zero && sgn_b;
		mag_a   = neg_a ? (0 - am) : am;
		mag_b   = neg_b ? (0 - bm) : bm;
		if (is_word_op(op_in)) begin
			mag_a[XLEN-1:HALF] = '0;
			mag_b[XLEN-1:HALF] = '0;
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage 1: capture operands and early results
	always_ff @(posedge clk) begin
		op_s1     <= op_in;
		a_s1      <= operand_a;
		b_s1      <= operand_b;
		simple_s1 <= simple_res;
		dvd_s1    <= mag_a;
		dvs_s1    <= mag_b;
		negq_s1   <= neg_a ^ neg_b;
		negr_s1   <= neg_a;
	end

	// stage 2: partial products
	always_ff @(posedge clk) begin
		op_s2     <= op_s1;
		a_s2      <= a_s1;
		b_s2      <= b_s1;
		simple_s2 <= simple_s1;
		dvd_s2    <= dvd_s1;
		dvs_s2    <= dvs_s1;
		negq_s2   <= negq_s1;
		negr_s2   <= negr_s1;
		pp_ll_s2  <= a_s1[HALF-1:0] * b_s1[HALF-1:0];
		pp_lh_s2  <= a_s1[HALF-1:0] * b_s1[XLEN-1:HALF];
		pp_hl_s2  <= a_s1[XLEN-1:HALF] * b_s1[HALF-1:0];
		pp_hh_s2  <= a_s1[XLEN-1:HALF] * b_s1[XLEN-1:HALF];
	end

	// stage 3: sum partial products
	always_ff @(posedge clk) begin
		op_s3     <= op_s2;
		a_s3      <= a_s2;
		b_s3      <= b_s2;
		simple_s3 <= simple_s2;
		dvd_s3    <= dvd_s2;
		dvs_s3    <= dvs_s2;
		negq_s3   <= negq_s2;
		negr_s3   <= negr_s2;
		prod_s3   <= {pp_hh_s2, pp_ll_s2}
			+ {{HALF{1'b0}}, pp_lh_s2, {HALF{1'b0}}}
			+ {{HALF{1'b0}}, pp_hl_s2, {HALF{1'b0}}};
	end

	// signed corrections of the high half
	always_comb begin
		mul_hi = prod_s3[2*XLEN-1:XLEN];
		if (a_s3[XLEN-1] && (op_s3 == OP_MULH || op_s3 == OP_MULHSU)) begin
			mul_hi = mul_hi - b_s3;
		end
		if (b_s3[XLEN-1] && op_s3 == OP_MULH) begin
			mul_hi = mul_hi - a_s3;
		end
	end

	// stage 4: pick the early result
	always_ff @(posedge clk) begin
		op_s4     <= op_s3;
		dvd_s4    <= dvd_s3;
		dvs_s4    <= dvs_s3;
		negq_s4   <= negq_s3;
		negr_s4   <= negr_s3;
		unique case (op_s3)
			OP_MUL:                       early_s4 <= prod_s3[XLEN-1:0];
			OP_MULW:                      early_s4 <= sext32(prod_s3[HALF-1:0]);
			OP_MULH, OP_MULHSU, OP_MULHU: early_s4 <= mul_hi;
			default:                      early_s4 <= simple_s3;
		endcase
	end

	assign tag_in = '{op: op_s4, neg_q: negq_s4, neg_r: negr_s4, early: early_s4};

	rvalu_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (vld_s4),
		.in_tag    (tag_in),
		.dividend  (dvd_s4),
		.divisor   (dvs_s4),
		.out_vld   (dv_out_vld),
		.out_tag   (dv_out_tag),
		.quotient  (dv_quo),
		.remainder (dv_rem)
	);

	// apply signs and word extension to the divider output
	always_comb begin
		if (is_rem_op(dv_out_tag.op)) begin
			dv_pick   = dv_rem;
			dv_signed = dv_out_tag.neg_r ? (0 - dv_pick) : dv_pick;
		end else begin
			dv_pick   = dv_quo;
			dv_signed = dv_out_tag.neg_q ? (0 - dv_pick) : dv_pick;
		end
		if (!is_div_op(dv_out_tag.op)) begin
			final_res = dv_out_tag.early;
		end else if (is_word_op(dv_out_tag.op)) begin
			final_res = sext32(dv_signed[HALF-1:0]);
		end else begin
			final_res = dv_signed;
		end
	end

	// drive the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_out_vld;
		end
	end

	// hold the result word
	always_ff @(posedge clk) begin
		result_q <= final_res;
	end

	assign done       = done_q;
	assign alu_result = result_q;

	`ASSERT_NEVER(a_never_busy, clk, arst_n, busy)
	`ASSERT_NEXT(a_enter, clk, arst_n, start, vld_s1)
	`ASSERT_NEXT(a_leave, clk, arst_n, dv_out_vld, done)
	`ASSERT_IMPLIES(a_div_zero, clk, arst_n,
		vld_s4 && is_div_op(op_s4) && dvs_s4 == '0, !negq_s4 && !negr_s4)
endmodule
`default_nettype wire
